>>> sv/atm_pkg.sv
// ----------------------------------------------------------------------------
// atm_pkg: shared types and constants for the accelerometer tilt/magnitude unit
// Payload structs, register indexes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
package atm_pkg;

  localparam int AngleIterDefault = 16;
  localparam int AtanSteps        = 24;
  localparam int HalfTurnCd       = 18000;

  // CORDIC datapath width: |dot|,|cross| < 2^31, scaled by 2^16, plus growth
  localparam int VecW = 50;
  localparam int AngW = 36;
  localparam int SqW  = 34;

  typedef enum logic [0:0] {
    REG_REF_X = 1'b0,
    REG_REF_Y = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] x_g;
    logic signed [15:0] y_g;
    logic signed [15:0] z_g;
    logic        [15:0] magnitude_g;
    logic signed [15:0] tilt_centideg;
  } out_item_t;

  function automatic logic signed [AngW-1:0] atan_q16(input int i);
    logic signed [AngW-1:0] r;
    unique case (i)
      0: r = 36'sd294912000;  1: r = 36'sd174096719;  2: r = 36'sd91987925;
      3: r = 36'sd46694507;   4: r = 36'sd23437865;   5: r = 36'sd11730358;
      6: r = 36'sd5866610;    7: r = 36'sd2933484;    8: r = 36'sd1466764;
      9: r = 36'sd733385;     10: r = 36'sd366693;    11: r = 36'sd183346;
      12: r = 36'sd91673;     13: r = 36'sd45837;     14: r = 36'sd22918;
      15: r = 36'sd11459;     16: r = 36'sd5730;      17: r = 36'sd2865;
      18: r = 36'sd1432;      19: r = 36'sd716;       20: r = 36'sd358;
      21: r = 36'sd179;       22: r = 36'sd90;        23: r = 36'sd45;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/accel_tilt_and_magnitude_unit.sv
// ----------------------------------------------------------------------------
// accel_tilt_and_magnitude_unit
// Raw accelerometer sample to g values, magnitude and planar tilt angle.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake      | Payload
// in      | input     | valid / stall  | in_item_t (raw_x, raw_y, raw_z)
// out     | output    | valid / stall  | out_item_t
// cfg     | input     | valid / ready  | index, 16-bit data (ref_x, ref_y)
//
// One sample per cycle while out_stall_i is low. The pipeline is a product
// stage, a dot/cross stage, one CORDIC rotation per stage followed by pass
// stages, then a rounding stage. The 17-step square root runs alongside in
// the same stages, one bit per stage.
// Reset clears valid bits and reference registers. A stall freezes every
// stage at once; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module accel_tilt_and_magnitude_unit #(
  parameter int ANGLE_ITERATIONS = atm_pkg::AngleIterDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  atm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output atm_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import atm_pkg::*;

  localparam int NIt  = (ANGLE_ITERATIONS > AtanSteps) ? AtanSteps : ANGLE_ITERATIONS;
  localparam int SqSt = 17;        // square root bit steps
  localparam int NSt  = (NIt + 1 > SqSt) ? NIt + 1 : SqSt;  // rotation and pass stages

  logic signed [15:0] ref_x_q, ref_y_q;
  logic adv;
  assign adv        = !out_stall_i;
  assign in_stall_o = out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Write reference registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q <= '0;
      ref_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_REF_X: ref_x_q <= cfg_data_i;
        REG_REF_Y: ref_y_q <= cfg_data_i;
      endcase
    end
  end

  // Stage 0: products
  logic               v0_q;
  in_item_t           d0_q;
  logic signed [31:0] p_xx_q, p_yy_q, p_xy_q, p_yx_q;
  logic signed [31:0] s_xx_q, s_yy_q, s_zz_q;
  logic               zero0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d0_q    <= in_data_i;
      p_xx_q  <= ref_x_q * in_data_i.raw_x;
      p_yy_q  <= ref_y_q * in_data_i.raw_y;
      p_xy_q  <= ref_x_q * in_data_i.raw_y;
      p_yx_q  <= ref_y_q * in_data_i.raw_x;
      s_xx_q  <= in_data_i.raw_x * in_data_i.raw_x;
      s_yy_q  <= in_data_i.raw_y * in_data_i.raw_y;
      s_zz_q  <= in_data_i.raw_z * in_data_i.raw_z;
      zero0_q <= (in_data_i.raw_x == 0 && in_data_i.raw_y == 0) ||
                 (ref_x_q == 0 && ref_y_q == 0);
    end
  end

  // Stage 1: dot, cross, sum of squares, prerotation
  logic signed [32:0] dot_w, cross_w;
  assign dot_w   = 33'(p_xx_q) + 33'(p_yy_q);
  assign cross_w = 33'(p_xy_q) - 33'(p_yx_q);

  logic signed [VecW-1:0] vx_q [NSt+1];
  logic signed [VecW-1:0] vy_q [NSt+1];
  logic signed [AngW-1:0] ang_q [NSt+1];
  logic                   vv_q [NSt+1];
  in_item_t               dd_q [NSt+1];
  logic                   zz_q [NSt+1];
  logic [SqW-1:0]         sn_q [NSt+1];
  logic [SqW-1:0]         sr_q [NSt+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vv_q[0] <= 1'b0;
    else if (adv) vv_q[0] <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q[0] <= d0_q;
      zz_q[0] <= zero0_q;
      sn_q[0] <= SqW'($unsigned(s_xx_q)) + SqW'($unsigned(s_yy_q))
               + SqW'($unsigned(s_zz_q));
      sr_q[0] <= '0;
      if (dot_w < 0) begin
        vx_q[0]  <= -(VecW'(dot_w) <<< 16);
        vy_q[0]  <= -(VecW'(cross_w) <<< 16);
        ang_q[0] <= (cross_w >= 0) ? AngW'(HalfTurnCd * 65536)
                                   : -AngW'(HalfTurnCd * 65536);
      end else begin
        vx_q[0]  <= VecW'(dot_w) <<< 16;
        vy_q[0]  <= VecW'(cross_w) <<< 16;
        ang_q[0] <= '0;
      end
    end
  end

  // CORDIC rotation and pass stages; each of the first SqSt stages also takes one square root bit step
  for (genvar g = 0; g < NSt; g++) begin : g_stage
    logic signed [VecW-1:0] nx, ny;
    logic signed [AngW-1:0] na;
    logic [SqW-1:0] bitv, nn, nr;
    always_comb begin
      nx = vx_q[g];
      ny = vy_q[g];
      na = ang_q[g];
      if (g < NIt) begin
        if (vy_q[g] >= 0) begin
          nx = vx_q[g] + (vy_q[g] >>> g);
          ny = vy_q[g] - (vx_q[g] >>> g);
          na = ang_q[g] + atan_q16(g);
        end else begin
          nx = vx_q[g] - (vy_q[g] >>> g);
          ny = vy_q[g] + (vx_q[g] >>> g);
          na = ang_q[g] - atan_q16(g);
        end
      end
      // restoring square root, bit 2*(16-g)
      nn = sn_q[g];
      nr = sr_q[g];
      bitv = '0;
      if (g < SqSt) begin
        bitv = SqW'(1) << (2 * (SqSt - 1 - g));
        if (sn_q[g] >= sr_q[g] + bitv) begin
          nn = sn_q[g] - (sr_q[g] + bitv);
          nr = (sr_q[g] >> 1) + bitv;
        end else begin
          nr = sr_q[g] >> 1;
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vv_q[g+1] <= 1'b0;
      else if (adv) vv_q[g+1] <= vv_q[g];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        vx_q[g+1]  <= nx;
        vy_q[g+1]  <= ny;
        ang_q[g+1] <= na;
        dd_q[g+1]  <= dd_q[g];
        zz_q[g+1]  <= zz_q[g];
        sn_q[g+1]  <= nn;
        sr_q[g+1]  <= nr;
      end
    end
  end

  // Output stage: round, clamp
  logic signed [AngW-1:0] rnd;
  logic signed [AngW-17:0] rsh;
  logic signed [15:0] tilt;
  assign rnd = ang_q[NSt] + AngW'(32768);
  assign rsh = rnd[AngW-1:16];
  always_comb begin
    if (zz_q[NSt]) tilt = '0;
    else if (rsh > HalfTurnCd) tilt = 16'(HalfTurnCd);
    else if (rsh < -HalfTurnCd) tilt = -16'(HalfTurnCd);
    else tilt = 16'(rsh);
  end

  logic      ov_q;
  out_item_t od_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= vv_q[NSt];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      od_q.x_g           <= dd_q[NSt].raw_x;
      od_q.y_g           <= dd_q[NSt].raw_y;
      od_q.z_g           <= dd_q[NSt].raw_z;
      od_q.magnitude_g   <= sr_q[NSt][15:0];
      od_q.tilt_centideg <= tilt;
    end
  end
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed under stall");
  a_stall_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == out_stall_i) else $error("stall mismatch");
  a_tilt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.tilt_centideg <= 16'sd18000 &&
                     out_data_o.tilt_centideg >= -16'sd18000))
    else $error("tilt out of range");
`endif

endmodule
